// File: design/slid_pkg.sv
// Shared types and constants for the sorted key store.
// No dependencies; slid_datapath, slid_ctrl and sorted_list_insert_delete use this package.
`timescale 1ns / 1ps

package slid_pkg;

  localparam int KEY_W = 32;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  typedef struct packed {
    logic                    command;
    logic signed [KEY_W-1:0] key;
  } cmd_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] stored_key;
    logic                    last;
    logic                    empty_res;
    logic                    not_found;
    logic                    overflow;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT0,
    S_DEL_RD,
    S_DEL_CMP,
    S_DUMP_RD,
    S_DUMP_OUT
  } state_t;

  // Store write kinds; all but WR_PUT_ZERO are relative to the scan index
  typedef enum logic [2:0] {
    WR_NONE,
    WR_SHIFT_UP,   // mem[idx+1] = read data
    WR_PUT_ABOVE,  // mem[idx+1] = key
    WR_PUT_ZERO,   // mem[0]     = key
    WR_SHIFT_DOWN  // mem[idx-1] = read data
  } wr_op_t;

  typedef struct packed {
    logic   accept;
    logic   rd_en;
    wr_op_t wr_op;
    logic   idx_clear;
    logic   idx_load_top;
    logic   idx_inc;
    logic   idx_dec;
    logic   cnt_inc;
    logic   cnt_dec;
    logic   set_found;
    logic   set_full;
    logic   set_miss;
    logic   out_load;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic is_delete;
    logic count_zero;
    logic full;
    logic idx_zero;
    logic idx_last;
    logic ge;
    logic eq;
    logic found;
    logic out_free;
  } status_t;

endpackage

// File: design/slid_stream_if.sv
// Valid/ready stream channel with a typed payload.
// Payload types come from slid_pkg at the point of instantiation.
`timescale 1ns / 1ps

interface slid_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: design/slid_datapath.sv
// Datapath: key store memory, scan index, entry count, flags and output register.
// Driven by slid_ctrl through slid_pkg::ctrl_t; reports slid_pkg::status_t.
`timescale 1ns / 1ps

module slid_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst,
  slid_stream_if.sink       cmd,
  slid_stream_if.source     res,
  input  slid_pkg::ctrl_t   ctrl,
  output slid_pkg::status_t st
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [slid_pkg::KEY_W-1:0] mem [CAPACITY];
  logic signed [slid_pkg::KEY_W-1:0] rd_data;
  logic signed [slid_pkg::KEY_W-1:0] key;
  logic                              command;
  logic [IW-1:0]                     idx;
  logic [CW-1:0]                     cnt;
  logic                              found;
  logic                              full_flag;
  logic                              miss;
  logic                              out_valid;
  slid_pkg::res_t                    out_reg;

  logic                              take;
  logic                              wr_en;
  logic [IW-1:0]                     wr_addr;
  logic signed [slid_pkg::KEY_W-1:0] wr_data;

  assign take        = cmd.valid && ctrl.accept;
  assign cmd.ready   = ctrl.accept;
  assign res.valid   = out_valid;
  assign res.payload = out_reg;

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = idx + IW'(1);
    wr_data = rd_data;
    unique case (ctrl.wr_op)
      slid_pkg::WR_NONE:       wr_en = 1'b0;
      slid_pkg::WR_SHIFT_UP:   wr_data = rd_data;
      slid_pkg::WR_PUT_ABOVE:  wr_data = key;
      slid_pkg::WR_PUT_ZERO: begin
        wr_addr = '0;
        wr_data = key;
      end
      slid_pkg::WR_SHIFT_DOWN: wr_addr = idx - IW'(1);
      default:                 wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_data <= mem[idx];
    end
    if (take) begin
      key     <= cmd.payload.key;
      command <= cmd.payload.command;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      cnt       <= '0;
      found     <= 1'b0;
      full_flag <= 1'b0;
      miss      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      priority if (ctrl.idx_clear) begin
        idx <= '0;
      end else if (ctrl.idx_load_top) begin
        idx <= IW'(cnt - CW'(1));
      end else if (ctrl.idx_inc) begin
        idx <= idx + IW'(1);
      end else if (ctrl.idx_dec) begin
        idx <= idx - IW'(1);
      end
      if (ctrl.cnt_inc) begin
        cnt <= cnt + CW'(1);
      end else if (ctrl.cnt_dec) begin
        cnt <= cnt - CW'(1);
      end
      if (take) begin
        found     <= 1'b0;
        full_flag <= 1'b0;
        miss      <= 1'b0;
      end else begin
        if (ctrl.set_found) found     <= 1'b1;
        if (ctrl.set_full)  full_flag <= 1'b1;
        if (ctrl.set_miss)  miss      <= 1'b1;
      end
      if (ctrl.out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_reg.stored_key <= st.count_zero ? '0 : rd_data;
      out_reg.last       <= st.count_zero || st.idx_last;
      out_reg.empty_res  <= st.count_zero;
      out_reg.not_found  <= miss;
      out_reg.overflow   <= full_flag;
    end
  end

  always_comb begin
    st.in_valid   = cmd.valid;
    st.is_delete  = (command == slid_pkg::CMD_DELETE);
    st.count_zero = (cnt == '0);
    st.full       = (cnt >= CW'(CAPACITY));
    st.idx_zero   = (idx == '0);
    st.idx_last   = ((CW'(idx) + CW'(1)) == cnt);
    st.ge         = (rd_data >= key);
    st.eq         = (rd_data == key);
    st.found      = found;
    st.out_free   = !out_valid || res.ready;
  end

endmodule

// File: design/slid_ctrl.sv
// Controller: sequences the insert scan, delete scan and list dump.
// Uses slid_pkg state, control and status types; drives slid_datapath.
`timescale 1ns / 1ps

module slid_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  slid_pkg::status_t st,
  output slid_pkg::ctrl_t   ctrl
);

  slid_pkg::state_t state;
  slid_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slid_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    ctrl.wr_op = slid_pkg::WR_NONE;
    unique case (state)
      slid_pkg::S_IDLE: begin
        ctrl.accept = 1'b1;
        if (st.in_valid) state_next = slid_pkg::S_START;
      end
      slid_pkg::S_START: begin
        if (!st.is_delete) begin
          if (st.full) begin
            ctrl.set_full  = 1'b1;
            ctrl.idx_clear = 1'b1;
            state_next     = slid_pkg::S_DUMP_RD;
          end else if (st.count_zero) begin
            ctrl.wr_op     = slid_pkg::WR_PUT_ZERO;
            ctrl.cnt_inc   = 1'b1;
            ctrl.idx_clear = 1'b1;
            state_next     = slid_pkg::S_DUMP_RD;
          end else begin
            ctrl.idx_load_top = 1'b1;
            state_next        = slid_pkg::S_INS_RD;
          end
        end else begin
          ctrl.idx_clear = 1'b1;
          if (st.count_zero) begin
            ctrl.set_miss = 1'b1;
            state_next    = slid_pkg::S_DUMP_RD;
          end else begin
            state_next = slid_pkg::S_DEL_RD;
          end
        end
      end
      // insert: walk down from the top, moving keys >= new key up one slot
      slid_pkg::S_INS_RD: begin
        ctrl.rd_en = 1'b1;
        state_next = slid_pkg::S_INS_CMP;
      end
      slid_pkg::S_INS_CMP: begin
        if (st.ge) begin
          ctrl.wr_op = slid_pkg::WR_SHIFT_UP;
          if (st.idx_zero) begin
            state_next = slid_pkg::S_INS_PUT0;
          end else begin
            ctrl.idx_dec = 1'b1;
            state_next   = slid_pkg::S_INS_RD;
          end
        end else begin
          ctrl.wr_op     = slid_pkg::WR_PUT_ABOVE;
          ctrl.cnt_inc   = 1'b1;
          ctrl.idx_clear = 1'b1;
          state_next     = slid_pkg::S_DUMP_RD;
        end
      end
      slid_pkg::S_INS_PUT0: begin
        ctrl.wr_op     = slid_pkg::WR_PUT_ZERO;
        ctrl.cnt_inc   = 1'b1;
        ctrl.idx_clear = 1'b1;
        state_next     = slid_pkg::S_DUMP_RD;
      end
      // delete: walk up; after the first match every key moves down one slot
      slid_pkg::S_DEL_RD: begin
        ctrl.rd_en = 1'b1;
        state_next = slid_pkg::S_DEL_CMP;
      end
      slid_pkg::S_DEL_CMP: begin
        if (st.found) begin
          ctrl.wr_op = slid_pkg::WR_SHIFT_DOWN;
        end else if (st.eq) begin
          ctrl.set_found = 1'b1;
        end
        if (st.idx_last) begin
          if (st.found || st.eq) begin
            ctrl.cnt_dec = 1'b1;
          end else begin
            ctrl.set_miss = 1'b1;
          end
          ctrl.idx_clear = 1'b1;
          state_next     = slid_pkg::S_DUMP_RD;
        end else begin
          ctrl.idx_inc = 1'b1;
          state_next   = slid_pkg::S_DEL_RD;
        end
      end
      slid_pkg::S_DUMP_RD: begin
        if (st.count_zero) begin
          if (st.out_free) begin
            ctrl.out_load = 1'b1;
            state_next    = slid_pkg::S_IDLE;
          end
        end else begin
          ctrl.rd_en = 1'b1;
          state_next = slid_pkg::S_DUMP_OUT;
        end
      end
      slid_pkg::S_DUMP_OUT: begin
        if (st.out_free) begin
          ctrl.out_load = 1'b1;
          if (st.idx_last) begin
            state_next = slid_pkg::S_IDLE;
          end else begin
            ctrl.idx_inc = 1'b1;
            state_next   = slid_pkg::S_DUMP_RD;
          end
        end
      end
      default: state_next = slid_pkg::S_IDLE;
    endcase
  end

endmodule

// File: design/sorted_list_insert_delete.sv
// Sorted key store: up to CAPACITY signed 32-bit keys kept in ascending order in a
// single-port-write, registered-read memory. A command beat inserts (before the first
// key >= it) or deletes (first equal key), then the whole list is dumped as result
// beats, last marking the final one; an empty list gives one beat with empty_res.
// The insert scan walks down from the top and the delete scan up through all stored keys,
// each step a registered memory read followed by a compare. An insert into a full list
// stores nothing and flags overflow, a delete with no equal key flags not_found. The dump
// then reads each key and loads it into the output register, waiting while the previous
// result beat is not yet taken. The next command is taken while the final result beat
// still waits in the output register.
// Depends on slid_pkg, slid_stream_if, slid_ctrl and slid_datapath.
`timescale 1ns / 1ps

module sorted_list_insert_delete #(
  parameter int CAPACITY = 16
) (
  input logic           clk,
  input logic           rst,
  slid_stream_if.sink   cmd,
  slid_stream_if.source res
);

  slid_pkg::ctrl_t   ctrl;
  slid_pkg::status_t st;

  slid_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .st   (st),
    .ctrl (ctrl)
  );

  slid_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .res  (res),
    .ctrl (ctrl),
    .st   (st)
  );

`ifndef SYNTH
  // store is never written in the cycle a result beat is loaded
  a_no_write_on_load: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_load |-> ctrl.wr_op == slid_pkg::WR_NONE)
    else $error("store write during output load");

  a_no_grow_when_full: assert property (@(posedge clk) disable iff (rst)
    ctrl.cnt_inc |-> !st.full)
    else $error("entry count grew past capacity");

  a_no_shrink_when_empty: assert property (@(posedge clk) disable iff (rst)
    ctrl.cnt_dec |-> !st.count_zero)
    else $error("entry count shrank below zero");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.payload.empty_res |-> res.payload.last)
    else $error("empty result beat without last");
`endif

endmodule
